### sv/frot_pkg.sv
// shared types and constants for the frame rotator
// no dependencies

package frot_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int COORD_W     = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
  localparam int SIZE_W      = 8;
  localparam int PIX_W       = 24;

  // request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  // rotation codes
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_90   = 2'd1;
  localparam logic [1:0] ROT_180  = 2'd2;
  localparam logic [1:0] ROT_270  = 2'd3;

  typedef struct packed {
    logic load;    // write the request pixel into the store
    logic fetch;   // latch address and step the readout position
    logic nready;  // latch a not-ready result
    logic rd;      // read the store at the latched address
  } frot_cmd_t;

  typedef struct packed {
    logic readout;  // frame complete, fetches are served
  } frot_stat_t;

endpackage

### sv/frot_ctrl.sv
// controller state machine of the frame rotator
// depends on frot_pkg

module frot_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                op,
  input  frot_pkg::frot_stat_t stat,
  output frot_pkg::frot_cmd_t  cmd,
  output logic                busy,
  output logic                done
);
  import frot_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (op == OP_LOAD) begin
            cmd.load = 1'b1;
          end else if (stat.readout) begin
            cmd.fetch  = 1'b1;
            state_next = ST_READ;
          end else begin
            cmd.nready = 1'b1;
            state_next = ST_RESULT;
          end
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_RESULT);

endmodule

### sv/frot_datapath.sv
// datapath of the frame rotator: config registers, frame store, counters
// and rotated address generation; depends on frot_pkg

module frot_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  frot_pkg::frot_cmd_t  cmd,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  output frot_pkg::frot_stat_t stat,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic                frame_end,
  output logic                not_ready
);
  import frot_pkg::*;

  localparam int SW = COORD_W + 2;  // signed coordinate width

  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic [1:0]        rotation_mode;

  logic [PIX_W-1:0]  store [STORE_DEPTH];
  logic [COUNT_W-1:0] load_count;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               readout_phase;

  logic [ADDR_W-1:0] addr;
  logic              hit;
  logic              last;
  logic              nr;
  logic [PIX_W-1:0]  mem_q;

  logic [SIZE_W-1:0]  w;
  logic [SIZE_W-1:0]  h;
  logic [SIZE_W-1:0]  dw;
  logic [SIZE_W-1:0]  dh;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] count_inc;
  logic [SW-1:0]      ys;
  logic [SW-1:0]      xs;
  logic               in_range;
  logic [ADDR_W-1:0]  idx;
  logic [COORD_W:0]   col_inc;
  logic [COORD_W:0]   row_inc;

  // effective size: zero means one, saturate at the maximum
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] mx);
    logic [SIZE_W-1:0] r;
    if (v == '0) r = SIZE_W'(1);
    else if (v > mx) r = mx;
    else r = v;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= SIZE_W'(MAX_WIDTH);
      frame_height  <= SIZE_W'(MAX_HEIGHT);
      rotation_mode <= ROT_NONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  frame_width   <= cfg_data;
        REG_HEIGHT: frame_height  <= cfg_data;
        REG_MODE:   rotation_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w     = eff_size(frame_width, SIZE_W'(MAX_WIDTH));
    h     = eff_size(frame_height, SIZE_W'(MAX_HEIGHT));
    total = COUNT_W'(w) * COUNT_W'(h);
    dw    = rotation_mode[0] ? h : w;
    dh    = rotation_mode[0] ? w : h;
    count_inc = load_count + COUNT_W'(1);
    case (rotation_mode)
      ROT_90: begin
        ys = SW'(h) - SW'(1) - SW'(out_col);
        xs = SW'(out_row);
      end
      ROT_180: begin
        ys = SW'(h) - SW'(1) - SW'(out_row);
        xs = SW'(w) - SW'(1) - SW'(out_col);
      end
      ROT_270: begin
        ys = SW'(out_col);
        xs = SW'(w) - SW'(1) - SW'(out_row);
      end
      default: begin
        ys = SW'(out_row);
        xs = SW'(out_col);
      end
    endcase
    // a negative or oversized coordinate reads as black
    in_range = !ys[SW-1] && !xs[SW-1] &&
               (ys[SW-2:0] < (SW-1)'(h)) && (xs[SW-2:0] < (SW-1)'(w));
    idx     = ADDR_W'(ys[COORD_W-1:0]) * ADDR_W'(w) + ADDR_W'(xs[COORD_W-1:0]);
    col_inc = {1'b0, out_col} + (COORD_W+1)'(1);
    row_inc = {1'b0, out_row} + (COORD_W+1)'(1);
  end

  // control state of the load and readout sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count    <= '0;
      out_row       <= '0;
      out_col       <= '0;
      readout_phase <= 1'b0;
    end else if (cmd.load && !readout_phase) begin
      if (count_inc >= total) begin
        load_count    <= '0;
        out_row       <= '0;
        out_col       <= '0;
        readout_phase <= 1'b1;
      end else begin
        load_count <= count_inc;
      end
    end else if (cmd.fetch) begin
      if (SIZE_W'(col_inc) >= dw) begin
        out_col <= '0;
        if (SIZE_W'(row_inc) >= dh) begin
          out_row       <= '0;
          readout_phase <= 1'b0;
          load_count    <= '0;
        end else begin
          out_row <= row_inc[COORD_W-1:0];
        end
      end else begin
        out_col <= col_inc[COORD_W-1:0];
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hit  <= 1'b0;
      last <= 1'b0;
      nr   <= 1'b0;
    end else if (cmd.fetch) begin
      hit  <= in_range;
      last <= (SIZE_W'(col_inc) >= dw) && (SIZE_W'(row_inc) >= dh);
      nr   <= 1'b0;
    end else if (cmd.nready) begin
      hit  <= 1'b0;
      last <= 1'b0;
      nr   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      addr <= idx;
    end
  end

  // frame store, one port
  always_ff @(posedge clk) begin
    if (cmd.load && !readout_phase) begin
      store[load_count[ADDR_W-1:0]] <= {in_red, in_green, in_blue};
    end else if (cmd.rd) begin
      mem_q <= store[addr];
    end
  end

  assign stat.readout = readout_phase;
  assign out_red   = hit ? mem_q[23:16] : 8'd0;
  assign out_green = hit ? mem_q[15:8]  : 8'd0;
  assign out_blue  = hit ? mem_q[7:0]   : 8'd0;
  assign frame_end = last;
  assign not_ready = nr;

endmodule

### sv/frame_rotator_rgb.sv
// top level of the rotating frame store
// depends on frot_pkg, frot_ctrl and frot_datapath

// frame_rotator_rgb: load requests (op 0) fill a 128 x 128 store of 24-bit
// pixels in source raster order; once width * height pixels are in, fetch
// requests (op 1) return the frame in destination raster order, rotated by
// 0, 90, 180 or 270 degrees, with frame_end on the last pixel, after which
// the block loads again. a request is taken when start is high and busy is
// low. a load gives no result, and is dropped during readout. a fetch
// passes through address generation, store read and result, an order set
// by the single registered read port of the store; a fetch while loading
// skips the store read and returns not_ready with a black pixel. each
// result is on the outputs for exactly one cycle with done high and cannot
// be held off, so sample it then. the store has no clearing pass: reading a
// location that was never loaded gives an undefined pixel. write config
// only while busy is low and no fetch result is pending.

module frame_rotator_rgb (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       op,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       done,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       frame_end,
  output logic       not_ready
);
  import frot_pkg::*;

  frot_cmd_t  cmd;   // commands from the controller
  frot_stat_t stat;  // status back from the datapath

  // sequencing of each request
  frot_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // store, counters and rotation arithmetic
  frot_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .stat      (stat),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .frame_end (frame_end),
    .not_ready (not_ready)
  );

  // a fetch request always occupies the block for the following cycle
  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_FETCH) |=> busy)
    else $error("fetch request did not raise busy");

  // results only while the block is occupied
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  // a not-ready result carries a black pixel and no frame end
  a_nready_zero: assert property (@(posedge clk) disable iff (rst)
    (done && not_ready) |->
      (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 && !frame_end))
    else $error("not-ready result with pixel data");

  // a result strobe lasts exactly one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

### dv/frame_rotator_rgb_tb.sv
// self-checking bench for frame_rotator_rgb: loads and fetches with random pacing,
// every result compared with a rotating frame-store predictor held here
// depends on frot_pkg and the frame_rotator_rgb rtl

module frame_rotator_rgb_tb;
  import frot_pkg::*;

  // unused register index, writes to it must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;

  // one request as driven on the ports
  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_req_t;

  // one result as seen on the ports
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    logic       nready;
  } pixel_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       op = OP_LOAD;
  logic [7:0] in_red = 8'd0;
  logic [7:0] in_green = 8'd0;
  logic [7:0] in_blue = 8'd0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_WIDTH;
  logic [7:0] cfg_data = 8'd0;
  logic       done;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;
  logic       not_ready;

  frame_rotator_rgb u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .frame_end (frame_end),
    .not_ready (not_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: our own copy of the frame store, counters and registers
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] shadow_store [STORE_DEPTH];
  int unsigned      load_cnt = 0;
  int unsigned      row_pos = 0;
  int unsigned      col_pos = 0;
  bit               reading = 1'b0;
  // loads always land at 0, 1, 2 ... so the ever-written part of the store
  // is a prefix of this length
  int unsigned      written_upto = 0;
  logic [7:0]       width_reg = 8'd128;
  logic [7:0]       height_reg = 8'd128;
  logic [1:0]       rot_reg = ROT_NONE;

  pixel_req_t req_queue [$];   // requests waiting for the driver
  pixel_res_t due_pixels [$];  // results predicted but not yet seen

  int mismatch_count = 0;
  int results_checked = 0;
  int requests_taken = 0;
  int frames_rotated = 0;
  int nready_replies = 0;
  int stim_count = 0;

  // a size register of zero reads as one, anything above the store limit saturates
  function automatic int eff_dim(logic [7:0] v, int maxv);
    if (v == 8'd0) return 1;
    return (v > maxv) ? maxv : int'(v);
  endfunction

  function automatic int frame_pixels();
    return eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT);
  endfunction

  // fetches still owed in the current readout; when the position already sits
  // outside a shrunken frame, one at a time is enough, the caller loops
  function automatic int fetches_left();
    int w;
    int h;
    int dw;
    int dh;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    dw = rot_reg[0] ? h : w;
    dh = rot_reg[0] ? w : h;
    if (row_pos < dh && col_pos < dw) return (dh - 1 - row_pos) * dw + dw - col_pos;
    return 1;
  endfunction

  // step the predictor by one accepted request
  task automatic advance_rotator(pixel_req_t rq);
    int         w;
    int         h;
    int         dw;
    int         dh;
    int         x;
    int         y;
    pixel_res_t res;
    logic [23:0] px;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    if (rq.op == OP_LOAD) begin
      // loads during readout vanish without trace
      if (reading) return;
      shadow_store[load_cnt] = {rq.red, rq.green, rq.blue};
      load_cnt++;
      if (load_cnt > written_upto) written_upto = load_cnt;
      // a shrunken size can leave the count already past the end
      if (load_cnt >= w * h) begin
        load_cnt = 0;
        row_pos = 0;
        col_pos = 0;
        reading = 1'b1;
      end
      return;
    end
    if (!reading) begin
      res = '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1};
      due_pixels.push_back(res);
      nready_replies++;
      return;
    end
    dw = rot_reg[0] ? h : w;
    dh = rot_reg[0] ? w : h;
    // destination row/column back to source y/x
    case (rot_reg)
      ROT_90: begin
        y = h - 1 - int'(col_pos);
        x = row_pos;
      end
      ROT_180: begin
        y = h - 1 - int'(row_pos);
        x = w - 1 - int'(col_pos);
      end
      ROT_270: begin
        y = col_pos;
        x = w - 1 - int'(row_pos);
      end
      default: begin
        y = row_pos;
        x = col_pos;
      end
    endcase
    // coordinates outside the current frame read as black
    if (x < 0 || y < 0 || x >= w || y >= h) px = 24'd0;
    else px = shadow_store[y * w + x];
    res = '{px[23:16], px[15:8], px[7:0], 1'b0, 1'b0};
    col_pos++;
    if (col_pos >= dw) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= dh) begin
        row_pos = 0;
        load_cnt = 0;
        reading = 1'b0;
        res.last = 1'b1;
        frames_rotated++;
      end
    end
    due_pixels.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of back-to-back requests with random gaps between them
  // ---------------------------------------------------------------------------
  pixel_req_t cur_req;
  int         burst_left = 0;
  int         gap_left = 0;

  always @(posedge clk) begin
    logic start_nxt;
    start_nxt = start;
    if (rst) begin
      start_nxt = 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      // request taken at this edge: predict before the next one overwrites it
      if (start && !busy) begin
        advance_rotator(cur_req);
        requests_taken++;
        start_nxt = 1'b0;
      end
      if (!start_nxt) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_queue.size() > 0) begin
          cur_req = req_queue.pop_front();
          op <= cur_req.op;
          in_red <= cur_req.red;
          in_green <= cur_req.green;
          in_blue <= cur_req.blue;
          start_nxt = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            gap_left = $urandom_range(1, 8);
          end
        end
      end
    end
    start <= start_nxt;
  end

  // ---------------------------------------------------------------------------
  // monitor: a result is only valid for the cycle that done is high
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string fname, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h",
                                results_checked, fname, got, want));
  endtask

  always @(posedge clk) begin
    pixel_res_t want;
    if (!rst && done) begin
      if (due_pixels.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want = due_pixels.pop_front();
        check_field("out_red", out_red, want.red);
        check_field("out_green", out_green, want.green);
        check_field("out_blue", out_blue, want.blue);
        check_field("frame_end", {7'd0, frame_end}, {7'd0, want.last});
        check_field("not_ready", {7'd0, not_ready}, {7'd0, want.nready});
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_load(logic [23:0] px, bit counted);
    req_queue.push_back(pixel_req_t'{OP_LOAD, px[23:16], px[15:8], px[7:0]});
    if (counted) stim_count++;
  endtask

  task automatic queue_fetch();
    req_queue.push_back(pixel_req_t'{OP_FETCH, 8'($urandom), 8'($urandom),
                                     8'($urandom)});
    stim_count++;
  endtask

  // loads while the frame fills, with the odd premature fetch mixed in
  task automatic queue_loads(int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) queue_fetch();
      queue_load(24'($urandom), 1'b1);
    end
  endtask

  // fetches during readout, with the odd stray load that must be dropped
  task automatic queue_fetches(int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) queue_load(24'($urandom), 1'b0);
      queue_fetch();
    end
  endtask

  // wait until every request is taken, every result seen and the block idle,
  // then let the clock run on, since loads leave no result behind
  task automatic wait_idle();
    @(negedge clk);
    while (req_queue.size() != 0 || start || busy || due_pixels.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    // the block takes the write at this edge
    case (idx)
      REG_WIDTH:  width_reg = val;
      REG_HEIGHT: height_reg = val;
      REG_MODE:   rot_reg = val[1:0];
      default:    ;
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic write_geometry(logic [7:0] w, logic [7:0] h, logic [7:0] m);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MODE, m);
  endtask

  // mostly small sizes; sometimes zero, one, the limit or beyond it
  function automatic logic [7:0] pick_dim();
    if ($urandom_range(0, 7) != 0) return 8'($urandom_range(1, 8));
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd128;
      3:       return 8'd255;
      default: return 8'($urandom_range(129, 254));
    endcase
  endfunction

  // junk in the upper bits now and then, the block only looks at two
  function automatic logic [7:0] pick_mode();
    logic [1:0] m;
    m = 2'($urandom_range(0, 3));
    return ($urandom_range(0, 3) == 0) ? {6'($urandom), m} : {6'd0, m};
  endfunction

  // keep frames to a few hundred pixels so a full readout stays cheap
  task automatic pick_geometry(output logic [7:0] w, output logic [7:0] h);
    w = pick_dim();
    h = pick_dim();
    if (eff_dim(w, MAX_WIDTH) * eff_dim(h, MAX_HEIGHT) > 256) begin
      if ($urandom_range(0, 1)) h = 8'($urandom_range(0, 2));
      else w = 8'($urandom_range(0, 2));
    end
  endtask

  // mid-readout resize: never let the frame reach store entries not yet loaded
  task automatic pick_safe_geometry(output logic [7:0] w, output logic [7:0] h);
    repeat (20) begin
      pick_geometry(w, h);
      if (eff_dim(w, MAX_WIDTH) * eff_dim(h, MAX_HEIGHT) <= written_upto) return;
    end
    w = 8'd1;
    h = 8'd1;
  endtask

  // top up the loads until readout starts
  task automatic complete_frame_load();
    int need;
    wait_idle();
    if (reading) return;
    need = frame_pixels() - int'(load_cnt);
    queue_loads((need < 1) ? 1 : need);
  endtask

  // fetch until the frame is done; batch is the count already known, if any
  task automatic run_readout(int batch);
    int cnt;
    cnt = batch;
    while (1) begin
      if (cnt == 0) begin
        wait_idle();
        if (!reading) break;
        cnt = fetches_left();
      end
      queue_fetches(cnt);
      cnt = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  logic [23:0] corner_px [6] = '{24'h000000, 24'hFFFFFF, 24'h55AA55,
                                 24'hAA55AA, 24'h0180FE, 24'h80017F};

  initial begin
    logic [7:0] w_val;
    logic [7:0] h_val;
    int         n;
    int         sel;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // fetch straight out of reset, frame not loaded yet
    queue_fetch();

    // zero sizes give a single-pixel frame; a load while reading is dropped,
    // and the fetch after the end of the frame is refused again
    write_geometry(8'd0, 8'd0, {6'd0, ROT_NONE});
    write_reg(REG_SPARE, 8'hA5);
    queue_load(24'hFFFFFF, 1'b1);
    queue_load(24'h000000, 1'b0);
    queue_fetch();
    queue_fetch();

    // 2 x 3 turned by ninety with extreme colour values
    write_geometry(8'd2, 8'd3, {6'd0, ROT_90});
    foreach (corner_px[i]) queue_load(corner_px[i], 1'b1);
    repeat (6) queue_fetch();

    // single column and single row for the other two angles
    write_geometry(8'd1, 8'd2, {6'd0, ROT_270});
    repeat (2) queue_load(24'($urandom), 1'b1);
    repeat (2) queue_fetch();
    write_geometry(8'd2, 8'd1, {6'd0, ROT_180});
    repeat (2) queue_load(24'($urandom), 1'b1);
    repeat (2) queue_fetch();

    // random frames: mostly clean load-then-readout, some resized while
    // filling, some reconfigured half way through readout
    while (stim_count < 1125) begin
      pick_geometry(w_val, h_val);
      write_geometry(w_val, h_val, pick_mode());
      n = frame_pixels();
      sel = $urandom_range(0, 99);
      if (sel < 70 || n == 1) begin
        complete_frame_load();
        run_readout(n);
      end else if (sel < 85 && load_cnt == 0) begin
        queue_loads($urandom_range(1, n - 1));
        pick_geometry(w_val, h_val);
        write_geometry(w_val, h_val, pick_mode());
        complete_frame_load();
        run_readout(0);
      end else begin
        complete_frame_load();
        queue_fetches($urandom_range(1, n - 1));
        wait_idle();
        if ($urandom_range(0, 1)) begin
          pick_safe_geometry(w_val, h_val);
          write_reg(REG_WIDTH, w_val);
          write_reg(REG_HEIGHT, h_val);
        end
        write_reg(REG_MODE, pick_mode());
        run_readout(0);
      end
    end

    // drain, then allow for the fetch pipeline before the verdict
    wait_idle();
    repeat (8) @(posedge clk);
    if (due_pixels.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_pixels.size()));

    $display("summary: %0d requests taken, %0d results checked", requests_taken,
             results_checked);
    $display("summary: %0d rotated frames, %0d not-ready replies", frames_rotated,
             nready_replies);
    if (mismatch_count == 0) begin
      $display("frame_rotator_rgb verification clean");
    end else begin
      $display("frame_rotator_rgb verification failed");
    end
    $finish;
  end

  // hang guard, far above the slowest plausible run
  initial begin
    #5000000;
    $display("frame_rotator_rgb verification failed");
    $finish;
  end

endmodule
